FILE: rtl/bfs_pkg.sv
package bfs_pkg;

  localparam int unsigned DEPTH_DEF = 8;

  localparam logic [7:0] EMPTY_DEQ_BYTE = 8'h7E;
  localparam logic [7:0] CH_LO_A        = 8'h61;
  localparam logic [7:0] CH_LO_Z        = 8'h7A;
  localparam logic [7:0] CH_UP_A        = 8'h41;
  localparam logic [7:0] CH_UP_Z        = 8'h5A;
  localparam logic [7:0] CASE_OFFSET    = CH_LO_A - CH_UP_A;

  typedef enum logic [2:0] {
    K_ENQ     = 3'd0,
    K_DEQ     = 3'd1,
    K_PEEK    = 3'd2,
    K_SEARCH  = 3'd3,
    K_REPLACE = 3'd4,
    K_UPPER   = 3'd5,
    K_LOWER   = 3'd6,
    K_CLEAR   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_SCAN,
    S_OUT
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ENQ,
    OP_REPLACE,
    OP_CLEAR,
    OP_EMPTY_RD,
    OP_RD_HEAD,
    OP_RD_TAIL,
    OP_POP,
    OP_PEEK,
    OP_CASE,
    OP_SCAN_START,
    OP_SCAN_STEP,
    OP_FOUND,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    kind_e kind;
    logic  empty;
    logic  full;
    logic  match;
    logic  scan_end;
    logic  out_free;
  } dp_sts_t;

  function automatic logic [7:0] recase(input logic [7:0] b, input kind_e kind);
    logic [7:0] r;
    r = b;
    if (kind == K_UPPER) begin
      if (b >= CH_LO_A && b <= CH_LO_Z) r = b - CASE_OFFSET;
    end else begin
      if (b >= CH_UP_A && b <= CH_UP_Z) r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

FILE: rtl/bfs_ctrl.sv
module bfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bfs_pkg::dp_sts_t sts_i,
  output bfs_pkg::dp_op_e  op_o
);
  import bfs_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_OUT;
        unique case (sts_i.kind)
          K_ENQ:     op_o = OP_ENQ;
          K_REPLACE: op_o = OP_REPLACE;
          K_CLEAR:   op_o = OP_CLEAR;
          K_DEQ, K_PEEK: begin
            if (sts_i.empty) begin
              op_o = OP_EMPTY_RD;
            end else begin
              op_o    = OP_RD_HEAD;
              state_d = S_FETCH;
            end
          end
          K_SEARCH: begin
            if (!sts_i.empty) begin
              op_o    = OP_SCAN_START;
              state_d = S_SCAN;
            end
          end
          K_UPPER, K_LOWER: begin
            if (!sts_i.empty) begin
              op_o    = OP_RD_TAIL;
              state_d = S_FETCH;
            end
          end
          default: op_o = OP_NONE;
        endcase
      end
      S_FETCH: begin
        state_d = S_OUT;
        unique case (sts_i.kind)
          K_DEQ:   op_o = OP_POP;
          K_PEEK:  op_o = OP_PEEK;
          default: op_o = OP_CASE;
        endcase
      end
      S_SCAN: begin
        // compare the entry read last cycle; fetch the next one unless the last held entry was reached
        priority if (sts_i.match) begin
          op_o    = OP_FOUND;
          state_d = S_OUT;
        end else if (sts_i.scan_end) begin
          state_d = S_OUT;
        end else begin
          op_o = OP_SCAN_STEP;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          op_o    = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == OP_SCAN_STEP |-> !sts_i.scan_end)
    else $error("scan step issued past the last held entry");

  a_exec_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == OP_LOAD |=> state_q == S_EXEC)
    else $error("accepted request not executed");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> !in_ready_o)
    else $error("request accepted while a result is pending");

endmodule

FILE: rtl/bfs_dp.sv
module bfs_dp #(
  parameter int unsigned DEPTH = bfs_pkg::DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfs_pkg::dp_op_e   op_i,
  input  logic [2:0]        kind_i,
  input  logic [7:0]        item_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        value_o,
  output logic              found_o,
  output logic [1:0]        status_o,
  output logic [3:0]        fill_count_o,
  output logic              full_o,
  output logic              empty_o,
  output bfs_pkg::dp_sts_t  sts_o
);
  import bfs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_data_q;
  kind_e            kind_q;
  logic [7:0]       item_q;
  logic [PTR_W-1:0] rp_q;
  logic [CNT_W-1:0] occ_q;
  logic [CNT_W-1:0] scan_q;
  logic [7:0]       value_q;
  logic             found_q;
  status_e          status_q;
  logic             out_valid_q;
  logic             full, empty;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;
  logic [PTR_W-1:0] tail_idx, newest_idx, scan_idx, next_rp;
  logic [31:0]      occ_ext;

  function automatic logic [PTR_W-1:0] wrap_idx(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] y;
    y = (x >= SUM_W'(DEPTH)) ? x - SUM_W'(DEPTH) : x;
    return y[PTR_W-1:0];
  endfunction

  assign full       = (occ_q == CNT_W'(DEPTH));
  assign empty      = (occ_q == '0);
  assign tail_idx   = wrap_idx(SUM_W'(rp_q) + SUM_W'(occ_q));
  assign newest_idx = wrap_idx(SUM_W'(rp_q) + SUM_W'(occ_q) - SUM_W'(1));
  assign scan_idx   = wrap_idx(SUM_W'(rp_q) + SUM_W'(scan_q));
  assign next_rp    = wrap_idx(SUM_W'(rp_q) + SUM_W'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = newest_idx;
    mem_wdata = item_q;
    mem_re    = 1'b0;
    mem_raddr = rp_q;
    unique case (op_i)
      OP_ENQ: begin
        mem_we    = !full;
        mem_waddr = tail_idx;
      end
      OP_REPLACE: mem_we = !empty;
      OP_CASE: begin
        mem_we    = 1'b1;
        mem_wdata = recase(rd_data_q, kind_q);
      end
      OP_RD_HEAD, OP_SCAN_START: mem_re = 1'b1;
      OP_RD_TAIL: begin
        mem_re    = 1'b1;
        mem_raddr = newest_idx;
      end
      OP_SCAN_STEP: begin
        mem_re    = 1'b1;
        mem_raddr = scan_idx;
      end
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem[mem_raddr];
  end

  // command and result registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        kind_q   <= kind_e'(kind_i);
        item_q   <= item_i;
        value_q  <= '0;
        found_q  <= 1'b0;
        status_q <= ST_OK;
      end
      OP_ENQ:        if (full) status_q <= ST_FULL;
      OP_EMPTY_RD: begin
        status_q <= ST_EMPTY;
        value_q  <= (kind_q == K_DEQ) ? EMPTY_DEQ_BYTE : '0;
      end
      OP_POP, OP_PEEK: value_q <= rd_data_q;
      OP_FOUND:        found_q <= 1'b1;
      OP_SCAN_START:   scan_q  <= CNT_W'(1);
      OP_SCAN_STEP:    scan_q  <= scan_q + CNT_W'(1);
      default:         value_q <= value_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      occ_q <= '0;
    end else begin
      unique case (op_i)
        OP_ENQ: if (!full) occ_q <= occ_q + CNT_W'(1);
        OP_POP: begin
          rp_q  <= next_rp;
          occ_q <= occ_q - CNT_W'(1);
        end
        OP_CLEAR: begin
          rp_q  <= '0;
          occ_q <= '0;
        end
        default: rp_q <= rp_q;
      endcase
    end
  end

  assign occ_ext = 32'(occ_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_OUT) begin
      value_o      <= value_q;
      found_o      <= found_q;
      status_o     <= status_q;
      fill_count_o <= occ_ext[3:0];
      full_o       <= full;
      empty_o      <= empty;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.kind     = kind_q;
  assign sts_o.empty    = empty;
  assign sts_o.full     = full;
  assign sts_o.match    = (rd_data_q == item_q);
  assign sts_o.scan_end = (scan_q == occ_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_ENQ && !full) |=> occ_q == CNT_W'($past(occ_q) + CNT_W'(1)))
    else $error("enqueue did not advance the count");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_POP |-> !empty)
    else $error("pop from an empty queue");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_OUT |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule

FILE: rtl/byte_fifo_with_search.sv
// Enqueue, replace, clear and requests on an empty queue pass from acceptance through
// the execute and output states; dequeue, peek and case edits add a fetch state.
// Member search reads one stored entry per cycle through the single memory read
// port until it finds a match or reaches the last held entry. A new request is taken
// the cycle after the result register loads, so no request overlaps the one before.
// Reset clears read pointer, count and handshake state; slot storage is not cleared.
module byte_fifo_with_search #(
  parameter int unsigned DEPTH = bfs_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] item
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] value, [8] found, [10:9] status, [14:11] fill_count,
  // [15] is_full_flag, [16] is_empty_flag, [23:17] zero
  output logic [23:0] m_axis_tdata_o
);
  import bfs_pkg::*;

  dp_op_e     op;
  dp_sts_t    sts;
  logic [7:0] value;
  logic       found;
  logic [1:0] status;
  logic [3:0] fill_count;
  logic       full, empty;

  bfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  bfs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .kind_i       (s_axis_tuser_i),
    .item_i       (s_axis_tdata_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .value_o      (value),
    .found_o      (found),
    .status_o     (status),
    .fill_count_o (fill_count),
    .full_o       (full),
    .empty_o      (empty),
    .sts_o        (sts)
  );

  assign m_axis_tdata_o = {7'b0, empty, full, fill_count, status, found, value};

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bfs_pkg::*;

  localparam int unsigned FIFO_DEPTH  = DEPTH_DEF;
  localparam int          RAND_CMDS   = 800;
  localparam int          DRAIN_WAIT  = FIFO_DEPTH + 8;
  localparam int          CYCLE_LIMIT = 250000;
  localparam int          SHOW_ERRORS = 10;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] item;
  } fifo_cmd_t;

  typedef struct packed {
    logic [7:0] value;
    logic       found;
    status_e    status;
    logic [3:0] fill;
    logic       full;
    logic       empty;
  } fifo_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;   // [7:0] item
  logic [2:0]  s_axis_tuser_i  = '0;   // [2:0] kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [7:0] value, [8] found, [10:9] status, [14:11] fill_count,
  // [15] is_full_flag, [16] is_empty_flag, [23:17] zero
  logic [23:0] m_axis_tdata_o;

  fifo_cmd_t    cmd_backlog[$];
  fifo_result_t result_due[$];

  // shadow copy of the queue contents
  logic [7:0]  shadow_slots[FIFO_DEPTH];
  int unsigned shadow_head;
  int unsigned shadow_held;

  int n_total;
  int n_taken;
  int n_results;
  int n_full_rejects;
  int n_empty_reads;
  int n_hits;
  int error_count;
  int cycle_count;

  byte_fifo_with_search #(.DEPTH(FIFO_DEPTH)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned slot_at(int unsigned offset);
    return (shadow_head + offset) % FIFO_DEPTH;
  endfunction

  // Advance the shadow queue by one request and return the result it owes.
  function automatic fifo_result_t fifo_model_step(kind_e kind, logic [7:0] item);
    fifo_result_t r;
    int unsigned  tail;
    logic [7:0]   b;
    r = '0;
    r.status = ST_OK;
    tail = slot_at(shadow_held - 1);
    case (kind)
      K_ENQ: begin
        if (shadow_held >= FIFO_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_slots[slot_at(shadow_held)] = item;
          shadow_held++;
        end
      end
      K_DEQ: begin
        if (shadow_held == 0) begin
          r.value  = EMPTY_DEQ_BYTE;
          r.status = ST_EMPTY;
        end else begin
          r.value     = shadow_slots[shadow_head];
          shadow_head = (shadow_head + 1) % FIFO_DEPTH;
          shadow_held--;
        end
      end
      K_PEEK: begin
        if (shadow_held == 0) r.status = ST_EMPTY;
        else r.value = shadow_slots[shadow_head];
      end
      K_SEARCH: begin
        for (int unsigned i = 0; i < shadow_held; i++) begin
          if (shadow_slots[slot_at(i)] == item) r.found = 1'b1;
        end
      end
      K_REPLACE: begin
        if (shadow_held != 0) shadow_slots[tail] = item;
      end
      K_UPPER: begin
        if (shadow_held != 0) begin
          b = shadow_slots[tail];
          if (b >= CH_LO_A && b <= CH_LO_Z) shadow_slots[tail] = b - CASE_OFFSET;
        end
      end
      K_LOWER: begin
        if (shadow_held != 0) begin
          b = shadow_slots[tail];
          if (b >= CH_UP_A && b <= CH_UP_Z) shadow_slots[tail] = b + CASE_OFFSET;
        end
      end
      default: begin
        shadow_held = 0;
        shadow_head = 0;
      end
    endcase
    r.fill  = shadow_held[3:0];
    r.full  = (shadow_held == FIFO_DEPTH);
    r.empty = (shadow_held == 0);
    return r;
  endfunction

  function automatic int idle_phase();
    if (n_total == 0) return 2;
    return (n_taken * 3) / n_total;
  endfunction

  function automatic bit sender_pause();
    case (idle_phase())
      0:       return $urandom_range(99) < 18;
      1:       return $urandom_range(99) < 49;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_pause();
    case (idle_phase())
      0:       return $urandom_range(99) < 49;
      1:       return $urandom_range(99) < 18;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void note_mismatch(string field, int expv, int actv);
    if (error_count < SHOW_ERRORS) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, expv, actv);
    end
    error_count++;
  endfunction

  task automatic queue_cmd(kind_e kind, logic [7:0] item);
    fifo_cmd_t c;
    c.kind = kind;
    c.item = item;
    cmd_backlog.push_back(c);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    fifo_cmd_t c;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        result_due.push_back(fifo_model_step(kind_e'(s_axis_tuser_i), s_axis_tdata_i));
        n_taken++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (cmd_backlog.size() != 0 && !sender_pause()) begin
          c = cmd_backlog.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= c.item;
          s_axis_tuser_i  <= c.kind;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    fifo_result_t e;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (result_due.size() == 0) begin
          if (error_count < SHOW_ERRORS) begin
            $display("[%0t] result 0x%06h arrived with nothing outstanding",
                     $realtime, m_axis_tdata_o);
          end
          error_count++;
        end else begin
          e = result_due.pop_front();
          n_results++;
          if (e.status == ST_FULL) n_full_rejects++;
          if (e.status == ST_EMPTY) n_empty_reads++;
          if (e.found) n_hits++;
          if (m_axis_tdata_o[7:0] !== e.value)
            note_mismatch("value", e.value, m_axis_tdata_o[7:0]);
          if (m_axis_tdata_o[8] !== e.found)
            note_mismatch("found", e.found, m_axis_tdata_o[8]);
          if (m_axis_tdata_o[10:9] !== e.status)
            note_mismatch("status", e.status, m_axis_tdata_o[10:9]);
          if (m_axis_tdata_o[14:11] !== e.fill)
            note_mismatch("fill_count", e.fill, m_axis_tdata_o[14:11]);
          if (m_axis_tdata_o[15] !== e.full)
            note_mismatch("is_full_flag", e.full, m_axis_tdata_o[15]);
          if (m_axis_tdata_o[16] !== e.empty)
            note_mismatch("is_empty_flag", e.empty, m_axis_tdata_o[16]);
        end
      end
      m_axis_tready_i <= !receiver_pause();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, result_due.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    logic [7:0] recent_keys[FIFO_DEPTH];
    int         mode;
    int         roll;
    int         key_wr;
    kind_e      k;
    logic [7:0] b;

    shadow_head = 0;
    shadow_held = 0;
    key_wr      = 0;
    foreach (recent_keys[i]) recent_keys[i] = '0;

    // empty queue: every command that reads or edits
    queue_cmd(K_DEQ, 8'hFF);
    queue_cmd(K_PEEK, 8'h00);
    queue_cmd(K_SEARCH, 8'h00);
    queue_cmd(K_REPLACE, 8'h55);
    queue_cmd(K_UPPER, 8'h00);
    queue_cmd(K_LOWER, 8'h00);
    // case edits at the letter bounds and just outside them
    queue_cmd(K_ENQ, CH_LO_A);
    queue_cmd(K_UPPER, 8'h00);
    queue_cmd(K_LOWER, 8'h00);
    queue_cmd(K_ENQ, CH_LO_Z);
    queue_cmd(K_UPPER, 8'h00);
    queue_cmd(K_ENQ, 8'h40);
    queue_cmd(K_UPPER, 8'h00);
    queue_cmd(K_ENQ, 8'h5B);
    queue_cmd(K_LOWER, 8'h00);
    queue_cmd(K_ENQ, 8'h00);
    queue_cmd(K_ENQ, 8'hFF);
    queue_cmd(K_ENQ, 8'h60);
    queue_cmd(K_ENQ, 8'h7B);
    // full queue: reject, hit, miss, tail edit, then wrap
    queue_cmd(K_ENQ, 8'h11);
    queue_cmd(K_SEARCH, 8'hFF);
    queue_cmd(K_SEARCH, 8'h12);
    queue_cmd(K_REPLACE, CH_UP_Z);
    queue_cmd(K_LOWER, 8'h00);
    queue_cmd(K_DEQ, 8'h00);
    queue_cmd(K_ENQ, 8'hA5);
    queue_cmd(K_PEEK, 8'h00);
    queue_cmd(K_CLEAR, 8'h00);

    // random part in fill, drain and mixed stretches
    mode = 0;
    for (int n = 0; n < RAND_CMDS; n++) begin
      if (n % 24 == 0) mode = $urandom_range(2);
      roll = $urandom_range(99);
      if (roll < 3) k = K_CLEAR;
      else if (mode == 0 && roll < 58) k = K_ENQ;
      else if (mode == 1 && roll < 58) k = K_DEQ;
      else k = kind_e'($urandom_range(6));
      if ((k == K_SEARCH || k == K_REPLACE) && $urandom_range(1) == 1) begin
        b = recent_keys[$urandom_range(FIFO_DEPTH - 1)];
      end else begin
        case ($urandom_range(3))
          0:       b = CH_LO_A + 8'($urandom_range(25));
          1:       b = CH_UP_A + 8'($urandom_range(25));
          default: b = 8'($urandom_range(255));
        endcase
      end
      if (k == K_ENQ) begin
        recent_keys[key_wr] = b;
        key_wr = (key_wr + 1) % FIFO_DEPTH;
      end
      queue_cmd(k, b);
    end
    n_total = cmd_backlog.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || s_axis_tvalid_i || result_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (result_due.size() != 0) begin
      $display("%0d results never arrived", result_due.size());
      error_count++;
    end
    $display("ran %0d requests through the queue, %0d results checked", n_taken, n_results);
    $display("full rejects %0d, empty reads %0d, search hits %0d, mismatches %0d",
             n_full_rejects, n_empty_reads, n_hits, error_count);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
